// ===== sv/pdl_pkg.sv =====
// shared types and constants of the proximity led animator
package pdl_pkg;

  localparam int LED_COUNT_DEF = 10;

  localparam int DELAY_TOP   = 100;
  localparam int DELAY_FLOOR = 1;
  localparam int DELAY_CAP = 127;
  localparam int LEVEL_MAX = 31;

  // divider operand widths: raw * 99 and prox * (led count - 1) both fit 14 bits
  localparam int DIV_NUM_W = 14;
  localparam int DIV_DEN_W = 7;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK     = 2'd3;

  localparam logic [6:0]  DEADZONE_RST = 7'd5;
  localparam logic [6:0]  TOUCH_RST    = 7'd100;
  localparam logic [15:0] WINDOW_RST   = 16'd5000;
  localparam logic [4:0]  PEAK_RST     = 5'd20;

  typedef struct packed {
    logic [4:0] level;
    logic       falling;
    logic [4:0] peak;
  } led_entry_t;

endpackage

// ===== sv/pdl_div.sv =====
// restoring divider, one quotient bit per cycle
module pdl_div #(
  parameter int NUM_W = pdl_pkg::DIV_NUM_W,
  parameter int DEN_W = pdl_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== sv/pdl_led_mem.sv =====
// per-led state memory with registered read and valid bits
module pdl_led_mem #(
  parameter int DEPTH = pdl_pkg::LED_COUNT_DEF,
  parameter int IDX_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  pdl_pkg::led_entry_t wdata_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output pdl_pkg::led_entry_t rdata_o
);

  import pdl_pkg::*;

  led_entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  led_entry_t rd_q;
  logic       rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/proximity_led_animator.sv =====
// proximity led animator top level
// a transaction is taken in idle, then serial division follows
// (delay mapping and lit limit in two dividers side by side), then one result per cycle
// for each of LED_COUNT leds while the output is not stalled
// throughput: one input transaction per walk, set by the serial division and the led walk
// reset: control regs to defaults, led memory valid bits cleared at once, no clearing pass
module proximity_led_animator #(
  parameter int LED_COUNT = pdl_pkg::LED_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pdl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pdl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // proximity_sample, now_ms, rand_led, rand_peak, rand_target, rand_pause
  input  logic [pdl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // led_index, led_brightness, frame_delay_ms
  output logic [pdl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  // scanner_mode
  output logic                            m_axis_tuser
);

  import pdl_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [6:0] CNT7 = 7'(LED_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  // configuration
  logic [6:0]  deadzone_q, touch_q;
  logic [15:0] window_q;
  logic [4:0]  peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      touch_q    <= TOUCH_RST;
      window_q   <= WINDOW_RST;
      peak_q     <= PEAK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADZONE: deadzone_q <= cfg_data_i[6:0];
        CFG_TOUCH:    touch_q    <= cfg_data_i[6:0];
        CFG_WINDOW:   window_q   <= cfg_data_i[15:0];
        CFG_PEAK:     peak_q     <= cfg_data_i[4:0];
        default:      ;
      endcase
    end
  end

  // input fields
  logic [6:0]  raw;
  logic [31:0] now;
  logic [5:0]  rled, rtarget;
  logic [4:0]  rpeak;
  logic [3:0]  rpause;

  assign raw     = s_axis_tdata[6:0];
  assign now     = s_axis_tdata[38:7];
  assign rled    = s_axis_tdata[44:39];
  assign rpeak   = s_axis_tdata[49:45];
  assign rtarget = s_axis_tdata[55:50];
  assign rpause  = s_axis_tdata[59:56];

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q;
  logic             latch_q, latch_d;
  logic [31:0]      start_q, start_d;
  logic [5:0]       pos_q, pos_d, tgt_q, tgt_d, tgt_clamp;
  logic [3:0]       pause_q, pause_d;
  logic [5:0]       pause_add_q, pause_add_d;
  logic [4:0]       extra;
  logic             new_tgt;
  logic             active_q, active_d;
  logic [6:0]       prox;
  logic [31:0]      elapsed;
  logic [5:0]       rled_q;
  logic [4:0]       rpeak_q;
  logic [6:0]       lit_q, lit_d;
  logic [6:0]       limit_q, limit_d;
  logic [6:0]       delay_q, delay_d;
  logic [6:0]       base;
  logic [7:0]       delay_sum;
  logic             in_acc;
  logic             emit;
  logic             is_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // clamping, touch latch and scanner update
  always_comb begin
    latch_d = latch_q;
    start_d = start_q;
    prox    = raw;
    if (raw < deadzone_q) begin
      prox = '0;
    end else if (raw >= touch_q) begin
      prox = touch_q;
      if (!latch_q) begin
        latch_d = 1'b1;
        start_d = now;
      end
    end else begin
      latch_d = 1'b0;
    end
    elapsed  = now - start_d;
    active_d = latch_d && (elapsed < {16'b0, window_q});

    tgt_clamp = rtarget;
    if (tgt_clamp == '0) begin
      tgt_clamp = 6'd1;
    end
    if ({1'b0, tgt_clamp} >= CNT7) begin
      tgt_clamp = 6'(LED_COUNT - 1);
    end
    new_tgt = (pos_q == tgt_q);
    tgt_d   = new_tgt ? tgt_clamp : tgt_q;
    pause_d = new_tgt ? rpause : pause_q;
    extra   = new_tgt ? {rpause, 1'b0} : '0;
    if (pos_q < tgt_d) begin
      pos_d = pos_q + 1'b1;
    end else if (pos_q != '0) begin
      pos_d = pos_q - 1'b1;
    end else begin
      pos_d = pos_q;
    end
    pause_add_d = 6'(pause_d) + 6'(extra);
  end

  // dividers for delay mapping and lit limit
  logic                 dly_done, lim_done;
  logic [DIV_NUM_W-1:0] dly_quo, lim_quo;

  pdl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_dly_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .num_i   (DIV_NUM_W'(raw) * DIV_NUM_W'(DELAY_TOP - DELAY_FLOOR)),
    .den_i   (touch_q),
    .done_o  (dly_done),
    .quo_o   (dly_quo)
  );

  pdl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_lim_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .num_i   (DIV_NUM_W'(prox) * DIV_NUM_W'(LED_COUNT - 1)),
    .den_i   (touch_q >> 1),
    .done_o  (lim_done),
    .quo_o   (lim_quo)
  );

  always_comb begin
    if (touch_q == '0 || dly_quo >= DIV_NUM_W'(DELAY_TOP - DELAY_FLOOR)) begin
      base = 7'(DELAY_FLOOR);
    end else begin
      base = 7'(DELAY_TOP) - dly_quo[6:0];
    end
    delay_sum = {1'b0, base} + (active_q ? {2'b0, pause_add_q} : 8'd0);
    delay_d   = (delay_sum > 8'(DELAY_CAP)) ? 7'(DELAY_CAP) : delay_sum[6:0];
    if ((touch_q >> 1) == '0 || lim_quo >= DIV_NUM_W'(LED_COUNT)) begin
      limit_d = CNT7;
    end else begin
      limit_d = lim_quo[6:0] + 7'd1;
    end
  end

  // led memory walk
  logic [IDX_W-1:0] raddr;
  led_entry_t       ent, ent_d;
  logic [4:0]       bright;

  assign is_last = (idx_q == LAST_IDX);
  assign emit    = (state_q == ST_WALK) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    if (state_q == ST_WALK) begin
      raddr = (emit && !is_last) ? idx_q + 1'b1 : (emit ? '0 : idx_q);
    end else begin
      raddr = '0;
    end
  end

  pdl_led_mem #(
    .DEPTH (LED_COUNT),
    .IDX_W (IDX_W)
  ) u_led_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (emit && !active_q),
    .waddr_i (idx_q),
    .wdata_i (ent_d),
    .raddr_i (raddr),
    .rdata_o (ent)
  );

  always_comb begin
    ent_d = ent;
    lit_d = lit_q;
    if (ent.level != '0) begin
      if (ent.falling) begin
        ent_d.level = ent.level - 1'b1;
        if (ent.level == 5'd1) begin
          ent_d.falling = 1'b0;
          if (lit_q != '0) begin
            lit_d = lit_q - 1'b1;
          end
        end
      end else begin
        if (ent.level < 5'(LEVEL_MAX)) begin
          ent_d.level = ent.level + 1'b1;
        end
        if (ent_d.level >= ent.peak) begin
          ent_d.falling = 1'b1;
        end
      end
    end else if (rled_q == 6'(idx_q) && lit_q < limit_q) begin
      lit_d         = lit_q + 1'b1;
      ent_d.level   = 5'd1;
      ent_d.falling = 1'b0;
      ent_d.peak    = rpeak_q;
    end
    if (active_q) begin
      bright = (6'(idx_q) == pos_q) ? peak_q : '0;
    end else begin
      bright = ent_d.level;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_DIV;
      ST_DIV:  if (dly_done) state_d = ST_WALK;
      ST_WALK: if (emit && is_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      latch_q       <= 1'b0;
      start_q       <= '0;
      pos_q         <= '0;
      tgt_q         <= '0;
      pause_q       <= '0;
      lit_q         <= '0;
      active_q      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        latch_q  <= latch_d;
        start_q  <= start_d;
        active_q <= active_d;
        if (active_d) begin
          pos_q   <= pos_d;
          tgt_q   <= tgt_d;
          pause_q <= pause_d;
        end
      end
      if (state_q == ST_DIV) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
      if (emit && !active_q) begin
        lit_q <= lit_d;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rled_q      <= rled;
      rpeak_q     <= rpeak;
      pause_add_q <= pause_add_d;
    end
    if (state_q == ST_DIV && dly_done && lim_done) begin
      delay_q <= delay_d;
      limit_q <= limit_d;
    end
    if (emit) begin
      m_axis_tlast <= is_last;
      m_axis_tuser <= active_q;
      m_axis_tdata <= {6'b0, delay_q, bright, 6'(idx_q)};
    end
  end

endmodule

// ===== tb/proximity_led_animator_test.sv =====
// self-checking testbench of the proximity led animator: streams ticks and checks every led result
`timescale 1ns / 1ps

module proximity_led_animator_test;
  import pdl_pkg::*;

  localparam int LED_COUNT = LED_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [6:0]  prox_raw;
    logic [31:0] now_ms;
    logic [5:0]  pick_led;
    logic [4:0]  peak_draw;
    logic [5:0]  target_draw;
    logic [3:0]  pause_draw;
  } tick_t;

  typedef struct {
    int led_idx;
    int level;
    int scanner;
    int frame_delay;
    int last_led;
  } led_result_t;

  typedef enum {TICK_TOUCH, TICK_HOLD, TICK_BREATH, TICK_NOISE} tick_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  // configuration and animation state as the block should hold it
  logic [6:0]  dead_level = DEADZONE_RST;
  logic [6:0]  touch_level = TOUCH_RST;
  logic [15:0] window_ms = WINDOW_RST;
  logic [4:0]  scan_peak = PEAK_RST;
  bit          touch_latched;
  logic [31:0] touch_start;
  int          led_level[LED_COUNT];
  bit          led_falling[LED_COUNT];
  int          led_peak[LED_COUNT];
  int          lit_count;
  int          scan_pos;
  int          scan_tgt;
  int          scan_hold;

  led_result_t expected_leds[$];
  led_result_t oldest_led;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          tx_idle_pct = 11;
  int          rx_idle_pct = 11;
  logic [31:0] clock_ms = 32'd0;

  proximity_led_animator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void predict_tick(input tick_t t);
    int frame_delay;
    int drop;
    int prox;
    int limit;
    int half;
    int tgt;
    logic [31:0] elapsed;
    bit active;
    led_result_t r;
    if (touch_level == 0) begin
      frame_delay = DELAY_FLOOR;
    end else begin
      drop = int'(t.prox_raw) * (DELAY_TOP - DELAY_FLOOR) / int'(touch_level);
      frame_delay = (drop >= DELAY_TOP - DELAY_FLOOR) ? DELAY_FLOOR : DELAY_TOP - drop;
    end
    if (t.prox_raw < dead_level) begin
      prox = 0;
    end else if (t.prox_raw >= touch_level) begin
      prox = int'(touch_level);
      if (!touch_latched) begin
        touch_latched = 1'b1;
        touch_start = t.now_ms;
      end
    end else begin
      prox = int'(t.prox_raw);
      touch_latched = 1'b0;
    end
    elapsed = t.now_ms - touch_start;
    active = touch_latched && (elapsed < {16'd0, window_ms});
    if (active) begin
      if (scan_pos == scan_tgt) begin
        tgt = int'(t.target_draw);
        if (tgt == 0) tgt = 1;
        if (tgt >= LED_COUNT) tgt = LED_COUNT - 1;
        scan_tgt = tgt;
        scan_hold = int'(t.pause_draw);
        frame_delay += 2 * int'(t.pause_draw);
      end
      if (scan_pos < scan_tgt) scan_pos++;
      else if (scan_pos > 0) scan_pos--;
      frame_delay += scan_hold;
    end else begin
      half = int'(touch_level >> 1);
      if (half == 0) begin
        limit = LED_COUNT;
      end else begin
        limit = prox * (LED_COUNT - 1) / half + 1;
        if (limit > LED_COUNT) limit = LED_COUNT;
      end
      for (int i = 0; i < LED_COUNT; i++) begin
        if (led_level[i] > 0) begin
          if (led_falling[i]) begin
            led_level[i]--;
            if (led_level[i] == 0) begin
              led_falling[i] = 1'b0;
              if (lit_count > 0) lit_count--;
            end
          end else begin
            if (led_level[i] < LEVEL_MAX) led_level[i]++;
            if (led_level[i] >= led_peak[i]) led_falling[i] = 1'b1;
          end
        end else if (int'(t.pick_led) == i) begin
          if (lit_count < limit) begin
            lit_count++;
            led_level[i] = 1;
            led_falling[i] = 1'b0;
            led_peak[i] = int'(t.peak_draw);
          end
        end
      end
    end
    if (frame_delay > DELAY_CAP) frame_delay = DELAY_CAP;
    for (int i = 0; i < LED_COUNT; i++) begin
      r.led_idx = i;
      if (active) r.level = (i == scan_pos) ? int'(scan_peak) : 0;
      else r.level = led_level[i];
      r.scanner = active ? 1 : 0;
      r.last_led = (i == LED_COUNT - 1) ? 1 : 0;
      r.frame_delay = frame_delay;
      expected_leds.push_back(r);
    end
  endfunction

  function automatic tick_t mk_tick(input int raw, input logic [31:0] now, input int led,
                                    input int peak, input int target, input int pause);
    tick_t t;
    t.prox_raw = 7'(raw);
    t.now_ms = now;
    t.pick_led = 6'(led);
    t.peak_draw = 5'(peak);
    t.target_draw = 6'(target);
    t.pause_draw = 4'(pause);
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, t.pause_draw, t.target_draw, t.peak_draw, t.pick_led, t.now_ms,
                t.prox_raw};
    do @(posedge clk_i); while (!s_tready);
    predict_tick(t);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input int dz, input int tl, input int win, input int pk);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_DEADZONE;
    cfg_data <= CFG_DATA_W'(dz);
    @(posedge clk_i);
    cfg_idx <= CFG_TOUCH;
    cfg_data <= CFG_DATA_W'(tl);
    @(posedge clk_i);
    cfg_idx <= CFG_WINDOW;
    cfg_data <= CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_idx <= CFG_PEAK;
    cfg_data <= CFG_DATA_W'(pk);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    dead_level = 7'(dz);
    touch_level = 7'(tl);
    window_ms = 16'(win);
    scan_peak = 5'(pk);
  endtask

  function automatic tick_t random_tick(input tick_kind_e kind);
    tick_t t;
    int r;
    r = $urandom_range(99);
    if (r < 3) clock_ms = $urandom;
    else if (r < 8) clock_ms += $urandom_range(8000);
    else clock_ms += $urandom_range(8);
    t.now_ms = clock_ms;
    case (kind)
      TICK_TOUCH: begin
        t.prox_raw = 7'($urandom_range(127, touch_level));
      end
      TICK_HOLD: begin
        t.prox_raw = (dead_level > 0) ? 7'($urandom_range(dead_level - 1)) : 7'd0;
      end
      TICK_BREATH: begin
        if (touch_level > dead_level) begin
          t.prox_raw = 7'($urandom_range(touch_level - 1, dead_level));
        end else begin
          t.prox_raw = 7'($urandom_range(127));
        end
      end
      default: begin
        t.prox_raw = 7'($urandom_range(127));
      end
    endcase
    t.pick_led = 6'(($urandom_range(99) < 70) ? $urandom_range(LED_COUNT - 1)
                                              : $urandom_range(63));
    t.peak_draw = 5'(($urandom_range(99) < 80) ? $urandom_range(19, 10) : $urandom_range(31));
    t.target_draw = 6'($urandom_range(63));
    t.pause_draw = 4'(($urandom_range(99) < 80) ? $urandom_range(9) : $urandom_range(15));
    return t;
  endfunction

  // bursts of touch and of breathing, with stray samples in between
  task automatic run_random(input int count);
    int sent;
    int run_len;
    int p;
    int q;
    tick_kind_e kind;
    sent = 0;
    while (sent < count) begin
      p = $urandom_range(99);
      run_len = (p < 85) ? $urandom_range(30, 4) : $urandom_range(5, 1);
      for (int k = 0; k < run_len && sent < count; k++) begin
        q = $urandom_range(99);
        if (p < 45) kind = (q < 85) ? TICK_TOUCH : (q < 95) ? TICK_HOLD : TICK_NOISE;
        else if (p < 85) kind = (q < 90) ? TICK_BREATH : (q < 95) ? TICK_HOLD : TICK_NOISE;
        else kind = TICK_NOISE;
        send_tick(random_tick(kind));
        sent++;
      end
    end
  endtask

  task automatic test_breathing_directed();
    send_tick(mk_tick(0, 32'd10, 0, 0, 1, 0));
    send_tick(mk_tick(50, 32'd11, 1, 1, 1, 0));
    send_tick(mk_tick(99, 32'd12, 2, 31, 1, 0));
    send_tick(mk_tick(4, 32'd13, 63, 10, 1, 0));
    send_tick(mk_tick(99, 32'd14, 3, 19, 1, 0));
    send_tick(mk_tick(60, 32'd15, 9, 10, 1, 0));
    send_tick(mk_tick(60, 32'd16, 10, 12, 1, 0));
    send_tick(mk_tick(60, 32'd17, 4, 15, 1, 0));
  endtask

  task automatic test_scanner_directed();
    send_tick(mk_tick(127, 32'hFFFF_FFF0, 0, 10, 0, 15));
    send_tick(mk_tick(100, 32'hFFFF_FFF3, 0, 10, 63, 9));
    send_tick(mk_tick(0, 32'h0000_0005, 0, 10, 5, 0));
    send_tick(mk_tick(110, 32'h0000_0006, 0, 10, 5, 0));
    send_tick(mk_tick(127, 32'h0000_0010, 0, 10, 5, 0));
    send_tick(mk_tick(127, 32'h0000_1800, 5, 15, 5, 0));
    send_tick(mk_tick(50, 32'h0000_1801, 6, 15, 5, 0));
    send_tick(mk_tick(127, 32'h0000_1802, 6, 15, 3, 2));
    clock_ms = 32'h0000_1802;
  endtask

  task automatic test_tiny_touch_level();
    set_config(0, 0, 5000, 20);
    send_tick(mk_tick(0, clock_ms, 0, 10, 4, 3));
    send_tick(mk_tick(127, clock_ms + 1, 0, 10, 4, 3));
    set_config(3, 1, 0, 31);
    send_tick(mk_tick(2, clock_ms + 2, 7, 11, 4, 3));
    send_tick(mk_tick(0, clock_ms + 3, 8, 11, 4, 3));
    send_tick(mk_tick(1, clock_ms + 4, 9, 11, 4, 3));
  endtask

  task automatic test_random_defaults();
    set_config(DEADZONE_RST, TOUCH_RST, WINDOW_RST, PEAK_RST);
    run_random(80);
  endtask

  task automatic test_random_high_extremes();
    set_config(0, 127, 65535, 31);
    run_random(80);
  endtask

  task automatic test_random_low_extremes();
    set_config(127, 2, 0, 1);
    run_random(80);
  endtask

  task automatic test_random_short_window();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(20, 60, 30, 7);
    run_random(80);
    tx_idle_pct = 11;
    rx_idle_pct = 11;
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 2; k++) begin
      set_config($urandom_range(127), $urandom_range(127, 2), $urandom_range(65535),
                 $urandom_range(31, 1));
      run_random(80);
    end
  endtask

  task automatic compare_field(input string name, input int led, input int want,
                               input int got);
    if (want != got) begin
      $display("%0t: led %0d %s expected %0d actual %0d", $time, led, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) begin
      if (expected_leds.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual tdata %h", $time, m_tdata);
        mismatches++;
      end else begin
        oldest_led = expected_leds.pop_front();
        compare_field("led_index", oldest_led.led_idx, oldest_led.led_idx,
                      int'(m_tdata[5:0]));
        compare_field("led_brightness", oldest_led.led_idx, oldest_led.level,
                      int'(m_tdata[10:6]));
        compare_field("scanner_mode", oldest_led.led_idx, oldest_led.scanner, int'(m_tuser));
        compare_field("frame_delay_ms", oldest_led.led_idx, oldest_led.frame_delay,
                      int'(m_tdata[17:11]));
        compare_field("last_led", oldest_led.led_idx, oldest_led.last_led, int'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("proximity_led_animator_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LED_COUNT; i++) begin
      led_level[i] = 0;
      led_falling[i] = 1'b0;
      led_peak[i] = 0;
    end
    touch_latched = 1'b0;
    touch_start = 32'd0;
    lit_count = 0;
    scan_pos = 0;
    scan_tgt = 0;
    scan_hold = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_breathing_directed();
    test_scanner_directed();
    test_tiny_touch_level();
    test_random_defaults();
    test_random_high_extremes();
    test_random_low_extremes();
    test_random_short_window();
    test_random_configs();
    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("proximity_led_animator_test OK");
    end else begin
      $display("proximity_led_animator_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pdl_pkg.sv
sv/pdl_div.sv
sv/pdl_led_mem.sv
sv/proximity_led_animator.sv
tb/proximity_led_animator_test.sv
